FILE: hw/rtl/spq_pkg.sv
// shared types and codes for the strict priority queue
package spq_pkg;
   localparam int unsigned CAP_BITS = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd50;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_SERVE = 2'd1,
      FUNC_UNDO = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_FULL = 3'd1,
      ST_BAD_CLASS = 3'd2,
      ST_EMPTY = 3'd3,
      ST_NO_UNDO = 3'd4
   } status_type;

   localparam logic [1:0] CLS_REGULAR = 2'd0;
   localparam logic [1:0] CLS_ONE = 2'd1;
   localparam logic [1:0] CLS_TWO = 2'd2;
   localparam logic [1:0] CLS_BAD = 2'd3;

   // control from the sequencer to one queue cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;
endpackage

FILE: hw/rtl/strict_priority_queue_with_undo.sv
// top level: three class cells, history stack and the operation sequencer
// start is taken at an edge where busy is low; busy is then high for one cycle, in which
// the queue heads and the history top (fetched from their registered memory ports during
// the idle cycle before) are used and the state is updated. The result word follows with
// rsp_valid high for exactly one cycle, the same cycle in which busy is low again, so the
// next start can be taken at the edge that ends the result cycle. The idle state between
// operations is needed for the registered memory reads.
// The receiver cannot stall, so every result must be taken in its cycle. No clearing pass.
module strict_priority_queue_with_undo #(
   parameter int unsigned QUEUE_DEPTH = 64,
   parameter int unsigned HISTORY_DEPTH = 64,
   parameter int unsigned ID_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_func,
   input  logic [15:0] req_customer_id,
   input  logic [1:0] req_customer_class,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_entry_id,
   output logic [1:0] rsp_entry_class,
   output logic [6:0] rsp_waiting_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [6:0] csr_capacity_limit
);
   localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
   // the limit register tops out at 127, so a deeper queue never bounds it further
   localparam int unsigned LIM_MAX = (QUEUE_DEPTH < 127) ? QUEUE_DEPTH : 127;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] cap_ff;
   logic [6:0] total_ff;
   logic [HW-1:0] top_ff;
   logic [FW-1:0] fill_ff;
   logic [1:0] func_ff;
   logic [ID_BITS-1:0] cid_ff;
   logic [1:0] ccls_ff;
   logic [ID_BITS+1:0] hist [HISTORY_DEPTH];
   logic [ID_BITS+1:0] hrd_ff;
   logic [HW-1:0] top_dec;

   assign csr_ready = 1'b1;
   assign busy = (state_ff == S_EXEC);
   assign top_dec = (top_ff == '0) ? HW'(HISTORY_DEPTH - 1) : top_ff - 1'b1;

   // cells
   spq_pkg::cell_ctl_type ctl [3];
   logic [ID_BITS-1:0] push_id, head_id [3];
   logic ne [3];
   genvar g;
   for (g = 0; g < 3; g++) begin : g_cell
      spq_cell #(.DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl[g]), .push_id(push_id),
         .head_id(head_id[g]), .not_empty(ne[g]));
   end

   logic [6:0] lim;
   logic full;
   always_comb begin
      lim = (cap_ff < 7'(LIM_MAX)) ? cap_ff : 7'(LIM_MAX);
      full = total_ff >= lim;
   end

   logic [2:0] st;
   logic [ID_BITS-1:0] eid;
   logic [1:0] ecls, rcls;
   logic do_push, do_pop;
   logic [1:0] pcls, pick;
   logic exec;
   always_comb begin
      exec = (state_ff == S_EXEC);
      st = spq_pkg::ST_OK;
      eid = '0;
      ecls = '0;
      do_push = 1'b0;
      do_pop = 1'b0;
      pcls = ccls_ff;
      push_id = cid_ff;
      rcls = (hrd_ff[1:0] == spq_pkg::CLS_BAD) ? spq_pkg::CLS_REGULAR : hrd_ff[1:0];
      if (ne[1]) pick = spq_pkg::CLS_ONE;
      else if (ne[2]) pick = spq_pkg::CLS_TWO;
      else pick = spq_pkg::CLS_REGULAR;
      case (spq_pkg::func_type'(func_ff))
         spq_pkg::FUNC_ADD: begin
            if (full) st = spq_pkg::ST_FULL;
            else if (ccls_ff == spq_pkg::CLS_BAD) st = spq_pkg::ST_BAD_CLASS;
            else begin
               do_push = 1'b1;
               eid = cid_ff;
               ecls = ccls_ff;
            end
         end
         spq_pkg::FUNC_SERVE: begin
            if (!(ne[0] || ne[1] || ne[2])) st = spq_pkg::ST_EMPTY;
            else begin
               do_pop = 1'b1;
               eid = head_id[pick];
               ecls = pick;
            end
         end
         spq_pkg::FUNC_UNDO: begin
            if (fill_ff == '0) st = spq_pkg::ST_NO_UNDO;
            else if (full) st = spq_pkg::ST_FULL;
            else begin
               do_push = 1'b1;
               pcls = rcls;
               push_id = hrd_ff[ID_BITS+1:2];
               eid = hrd_ff[ID_BITS+1:2];
               ecls = rcls;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
         ctl[i].push = exec && do_push && (pcls == 2'(i));
         ctl[i].pop = exec && do_pop && (pick == 2'(i));
      end
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= spq_pkg::CAP_RESET;
         total_ff <= '0;
         top_ff <= '0;
         fill_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) cap_ff <= csr_capacity_limit;
         rsp_valid <= exec;
         if (exec) begin
            total_ff <= total_ff + 7'(do_push) - 7'(do_pop);
            if (do_pop) begin
               top_ff <= (top_ff == HW'(HISTORY_DEPTH - 1)) ? '0 : top_ff + 1'b1;
               if (fill_ff != FW'(HISTORY_DEPTH)) fill_ff <= fill_ff + 1'b1;
            end else if (do_push && func_ff == spq_pkg::FUNC_UNDO) begin
               top_ff <= top_dec;
               fill_ff <= fill_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         func_ff <= req_func;
         cid_ff <= ID_BITS'(req_customer_id);
         ccls_ff <= req_customer_class;
      end
      if (exec && do_pop) hist[top_ff] <= {eid, ecls};
      hrd_ff <= hist[top_dec];
      if (exec) begin
         rsp_status <= st;
         rsp_entry_id <= 16'(eid);
         rsp_entry_class <= ecls;
         rsp_waiting_count <= total_ff + 7'(do_push) - 7'(do_pop);
      end
   end
endmodule

FILE: hw/rtl/spq_cell.sv
// one class queue cell: circular buffer memory with head, tail and length
module spq_cell #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned ID_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic [ID_BITS-1:0] push_id,
   output logic [ID_BITS-1:0] head_id,
   output logic not_empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LW = $clog2(DEPTH + 1);

   logic [ID_BITS-1:0] mem [DEPTH];
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0] len_ff, len_in;
   logic [ID_BITS-1:0] rd_ff;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      if ({1'b0, p} == AW'(DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   always_comb begin
      head_in = ctl.pop ? wrap_inc(head_ff) : head_ff;
      tail_in = ctl.push ? wrap_inc(tail_ff) : tail_ff;
      len_in = len_ff + LW'(ctl.push) - LW'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         len_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         len_ff <= len_in;
      end
   end

   // read the head through a registered port addressed by the next head pointer; write-through when pushing into empty
   always_ff @(posedge clock) begin
      if (ctl.push) mem[tail_ff] <= push_id;
      rd_ff <= mem[head_in];
   end

   logic bypass_ff;
   logic [ID_BITS-1:0] bypass_id_ff;
   always_ff @(posedge clock) begin
      bypass_ff <= ctl.push && (tail_ff == head_in);
      bypass_id_ff <= push_id;
   end

   assign head_id = bypass_ff ? bypass_id_ff : rd_ff;
   assign not_empty = (len_ff != '0);
endmodule
